FILE: rtl/core/swma_pkg.sv
`default_nettype none

package swma_pkg;

  localparam int unsigned NUM_BINS   = 256;
  localparam int unsigned BIN_W      = $clog2(NUM_BINS);
  localparam int unsigned WINDOW_MAX = 1024;
  localparam int unsigned RING_AW    = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W      = $clog2(WINDOW_MAX) + 1;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned TWICE_W    = BIN_W + 1;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 3;

  typedef logic [BIN_W-1:0]   bin_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [RING_AW-1:0] ring_addr_t;
  typedef logic [TWICE_W-1:0] twice_t;

  localparam len_t WL_RESET = LEN_W'(5);
  localparam len_t LEN_MAX  = LEN_W'(WINDOW_MAX);

  // Word index of the window length register on the APB port.
  localparam logic [APB_AW-3:0] REG_WINDOW_LENGTH = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEC_RD,
    ST_DEC_WR,
    ST_INC_RD,
    ST_INC_WR,
    ST_OUT
  } state_e;

  // Access to the histogram memory.
  typedef struct packed {
    logic re;
    bin_t raddr;
    logic we;
    bin_t waddr;
    cnt_t wdata;
  } bin_port_t;

  // Request to the rank scanner: the two ranks to locate, counted from 1.
  typedef struct packed {
    logic start;
    cnt_t rank_lo;
    cnt_t rank_hi;
  } scan_req_t;

  // Answer of the rank scanner: the bins holding the two ranks.
  typedef struct packed {
    logic done;
    bin_t val_lo;
    bin_t val_hi;
  } scan_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/swma_bin_mem.sv
`default_nettype none

// Histogram memory. A valid bit per bin makes an unwritten or cleared bin read as zero.
module swma_bin_mem (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  clear_i,
  input  swma_pkg::bin_port_t  port_i,
  output swma_pkg::cnt_t       rdata_o
);

  swma_pkg::cnt_t                  mem_q [swma_pkg::NUM_BINS];
  logic [swma_pkg::NUM_BINS-1:0]   vld_q;
  swma_pkg::cnt_t                  rd_q;
  logic                            rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (port_i.we) begin
      mem_q[port_i.waddr] <= port_i.wdata;
    end
    if (port_i.re) begin
      rd_q <= mem_q[port_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clear_i) begin
        vld_q <= '0;
      end else if (port_i.we) begin
        vld_q[port_i.waddr] <= 1'b1;
      end
      if (port_i.re) begin
        rd_vld_q <= vld_q[port_i.raddr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/swma_ring_mem.sv
`default_nettype none

// Sample ring. Entries must be written before their read data is used; the ring itself does not enforce this.
module swma_ring_mem (
  input  wire                   clk_i,
  input  wire                   we_i,
  input  swma_pkg::ring_addr_t  waddr_i,
  input  swma_pkg::bin_t        wdata_i,
  input  wire                   re_i,
  input  swma_pkg::ring_addr_t  raddr_i,
  output swma_pkg::bin_t        rdata_o
);

  swma_pkg::bin_t mem_q [swma_pkg::WINDOW_MAX];
  swma_pkg::bin_t rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule

`default_nettype wire

FILE: rtl/core/swma_rank_scan.sv
`default_nettype none

// Walks the histogram from bin zero, one read per cycle, and accumulates the
// counts until the upper rank is reached or the top bin has been seen.
module swma_rank_scan (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  swma_pkg::scan_req_t  req_i,
  input  swma_pkg::cnt_t       rdata_i,
  output logic                 rd_en_o,
  output swma_pkg::bin_t       rd_addr_o,
  output swma_pkg::scan_rsp_t  rsp_o
);

  logic                       busy_q;
  logic [swma_pkg::BIN_W:0]   issue_q;
  logic                       pend_q;
  swma_pkg::bin_t             pend_bin_q;
  swma_pkg::cnt_t             cum_q;
  logic                       found_lo_q;
  swma_pkg::bin_t             val_lo_q;
  swma_pkg::bin_t             val_hi_q;
  swma_pkg::cnt_t             rank_lo_q;
  swma_pkg::cnt_t             rank_hi_q;
  logic                       done_q;

  swma_pkg::cnt_t             cum_sum;
  logic                       hit_lo;
  logic                       hit_hi;
  logic                       last_bin;
  logic                       finish;

  assign rd_en_o   = busy_q && !issue_q[swma_pkg::BIN_W];
  assign rd_addr_o = issue_q[swma_pkg::BIN_W-1:0];

  assign cum_sum  = cum_q + rdata_i;
  assign hit_lo   = pend_q && !found_lo_q && (cum_sum >= rank_lo_q);
  assign hit_hi   = pend_q && (cum_sum >= rank_hi_q);
  assign last_bin = pend_q && (pend_bin_q == '1);
  assign finish   = busy_q && (hit_hi || last_bin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      issue_q    <= '0;
      pend_q     <= 1'b0;
      pend_bin_q <= '0;
      cum_q      <= '0;
      found_lo_q <= 1'b0;
      val_lo_q   <= '0;
      val_hi_q   <= '0;
      rank_lo_q  <= '0;
      rank_hi_q  <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= finish;
      if (req_i.start) begin
        busy_q     <= 1'b1;
        issue_q    <= '0;
        pend_q     <= 1'b0;
        cum_q      <= '0;
        found_lo_q <= 1'b0;
        val_lo_q   <= '0;
        val_hi_q   <= '0;
        rank_lo_q  <= req_i.rank_lo;
        rank_hi_q  <= req_i.rank_hi;
      end else if (busy_q) begin
        if (rd_en_o) begin
          issue_q <= issue_q + (swma_pkg::BIN_W + 1)'(1);
        end
        pend_q     <= rd_en_o && !finish;
        pend_bin_q <= rd_addr_o;
        if (pend_q) begin
          cum_q <= cum_sum;
        end
        if (hit_lo) begin
          val_lo_q   <= pend_bin_q;
          found_lo_q <= 1'b1;
        end
        if (hit_hi) begin
          val_hi_q <= pend_bin_q;
        end
        if (finish) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.val_lo = val_lo_q;
  assign rsp_o.val_hi = val_hi_q;

endmodule

`default_nettype wire

FILE: rtl/core/sliding_window_median_alert.sv
`default_nettype none

// Sliding-window median alert. Each sample transaction on the input channel
// yields exactly one result transaction. The block keeps the last
// window_length samples in a 1024-entry ring memory and a 256-bin count
// histogram memory. Once the window is full, the sample is compared with
// twice the window median (the sum of the values at ranks (L+1)/2 and
// L/2+1) before it enters the window, and alert is raised when the sample
// is at least that large; alert_count counts alerts and saturates. While
// the window fills, alert, window_full and twice_median are zero. During
// the fill a transaction passes through the histogram increment read and
// write states and then the output state. With a full window, the median
// is found by a scan that reads one histogram bin per cycle from bin zero
// up to the bin holding the upper middle rank, after which the oldest
// sample leaves the histogram and the new sample enters it. The scan uses
// the single histogram read port. The input stalls until a transaction
// has loaded the output register. A result that the receiver stalls holds
// the following transaction in its last stage until the output register
// frees up. No clearing pass is needed after reset: the histogram
// carries a valid bit per bin. Writing window_length (APB byte address 0)
// restarts the fill and empties the histogram, but keeps alert_count; it
// must only be done while the block is idle. Length 0 acts as 1 and values
// above 1024 act as 1024.
module sliding_window_median_alert (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,

  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [swma_pkg::BIN_W-1:0]           sample_value_i,

  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic                                 alert_o,
  output logic                                 window_full_o,
  output logic [swma_pkg::TWICE_W-1:0]         twice_median_o,
  output logic [swma_pkg::TOTAL_W-1:0]         alert_count_o,

  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [swma_pkg::APB_AW-1:0]          paddr,
  input  wire  [swma_pkg::APB_DW-1:0]          pwdata,
  output logic [swma_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);

  // Control and window state.
  swma_pkg::state_e            state_q, state_d;
  swma_pkg::len_t              wl_q, wl_d;
  swma_pkg::ring_addr_t        pos_q, pos_d;
  swma_pkg::cnt_t              fill_q, fill_d;
  logic [swma_pkg::TOTAL_W-1:0] total_q, total_d;

  // The transaction in flight.
  swma_pkg::bin_t              s_q, s_d;
  logic                        full_q, full_d;
  swma_pkg::twice_t            twice_q, twice_d;
  logic                        alert_q, alert_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  logic                        out_alert_q;
  logic                        out_full_q;
  swma_pkg::twice_t            out_twice_q;
  logic [swma_pkg::TOTAL_W-1:0] out_count_q;
  logic                        out_load;

  // Datapath helpers.
  swma_pkg::len_t              len_eff;
  logic                        full_now;
  logic [swma_pkg::LEN_W-1:0]  pos_inc;
  logic                        accept;
  logic                        cfg_wr;
  logic                        cfg_hit;

  // Memory and scanner connections.
  swma_pkg::bin_port_t         bin_port;
  swma_pkg::cnt_t              bin_rdata;
  logic                        ring_we;
  logic                        ring_re;
  swma_pkg::bin_t              ring_rdata;
  swma_pkg::scan_req_t         scan_req;
  swma_pkg::scan_rsp_t         scan_rsp;
  logic                        scan_rd_en;
  swma_pkg::bin_t              scan_rd_addr;

  swma_bin_mem u_bin_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_wr && cfg_hit),
    .port_i  (bin_port),
    .rdata_o (bin_rdata)
  );

  swma_ring_mem u_ring_mem (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (pos_q),
    .wdata_i (s_q),
    .re_i    (ring_re),
    .raddr_i (pos_q),
    .rdata_o (ring_rdata)
  );

  swma_rank_scan u_rank_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (scan_req),
    .rdata_i   (bin_rdata),
    .rd_en_o   (scan_rd_en),
    .rd_addr_o (scan_rd_addr),
    .rsp_o     (scan_rsp)
  );

  // APB register access. The only register is the window length.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_hit = (paddr[swma_pkg::APB_AW-1:2] == swma_pkg::REG_WINDOW_LENGTH);
  assign prdata  = cfg_hit ? swma_pkg::APB_DW'(wl_q) : '0;

  // Effective window length, clamped to 1..WINDOW_MAX.
  always_comb begin
    if (wl_q == '0) begin
      len_eff = swma_pkg::LEN_W'(1);
    end else if (wl_q > swma_pkg::LEN_MAX) begin
      len_eff = swma_pkg::LEN_MAX;
    end else begin
      len_eff = wl_q;
    end
  end

  assign full_now = (swma_pkg::LEN_W'(fill_q) >= len_eff);
  assign pos_inc  = swma_pkg::LEN_W'(pos_q) + swma_pkg::LEN_W'(1);

  assign in_stall_o = (state_q != swma_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == swma_pkg::ST_OUT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    wl_d        = wl_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    total_d     = total_q;
    s_d         = s_q;
    full_d      = full_q;
    twice_d     = twice_q;
    alert_d     = alert_q;
    out_valid_d = out_valid_q && out_stall_i;

    bin_port       = '0;
    ring_we        = 1'b0;
    ring_re        = 1'b0;
    scan_req.start   = 1'b0;
    scan_req.rank_lo = swma_pkg::CNT_W'((len_eff + swma_pkg::LEN_W'(1)) >> 1);
    scan_req.rank_hi = swma_pkg::CNT_W'((len_eff >> 1) + swma_pkg::LEN_W'(1));

    case (state_q)
      swma_pkg::ST_IDLE: begin
        if (accept) begin
          // Fetch the oldest sample now; it stays on the ring read port
          // until the histogram decrement.
          s_d     = sample_value_i;
          full_d  = full_now;
          twice_d = '0;
          ring_re = 1'b1;
          if (full_now) begin
            scan_req.start = 1'b1;
            state_d        = swma_pkg::ST_SCAN;
          end else begin
            state_d = swma_pkg::ST_INC_RD;
          end
        end
      end
      swma_pkg::ST_SCAN: begin
        bin_port.re    = scan_rd_en;
        bin_port.raddr = scan_rd_addr;
        if (scan_rsp.done) begin
          twice_d = swma_pkg::TWICE_W'(scan_rsp.val_lo) + swma_pkg::TWICE_W'(scan_rsp.val_hi);
          state_d = swma_pkg::ST_DEC_RD;
        end
      end
      swma_pkg::ST_DEC_RD: begin
        bin_port.re    = 1'b1;
        bin_port.raddr = ring_rdata;
        state_d        = swma_pkg::ST_DEC_WR;
      end
      swma_pkg::ST_DEC_WR: begin
        // The oldest sample leaves the histogram; an empty bin stays empty.
        bin_port.we    = 1'b1;
        bin_port.waddr = ring_rdata;
        bin_port.wdata = (bin_rdata == '0) ? '0 : bin_rdata - swma_pkg::CNT_W'(1);
        state_d        = swma_pkg::ST_INC_RD;
      end
      swma_pkg::ST_INC_RD: begin
        bin_port.re    = 1'b1;
        bin_port.raddr = s_q;
        state_d        = swma_pkg::ST_INC_WR;
      end
      swma_pkg::ST_INC_WR: begin
        bin_port.we    = 1'b1;
        bin_port.waddr = s_q;
        bin_port.wdata = bin_rdata + swma_pkg::CNT_W'(1);
        ring_we        = 1'b1;
        pos_d = (pos_inc >= len_eff) ? '0 : pos_inc[swma_pkg::RING_AW-1:0];
        if (!full_q) begin
          fill_d = fill_q + swma_pkg::CNT_W'(1);
        end
        alert_d = full_q && (swma_pkg::TWICE_W'(s_q) >= twice_q);
        if (alert_d && (total_q != '1)) begin
          total_d = total_q + swma_pkg::TOTAL_W'(1);
        end
        state_d = swma_pkg::ST_OUT;
      end
      swma_pkg::ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = swma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swma_pkg::ST_IDLE;
      end
    endcase

    // A window length write restarts the fill; the alert total is kept.
    if (cfg_wr && cfg_hit) begin
      wl_d   = pwdata[swma_pkg::LEN_W-1:0];
      pos_d  = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swma_pkg::ST_IDLE;
      wl_q        <= swma_pkg::WL_RESET;
      pos_q       <= '0;
      fill_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wl_q        <= wl_d;
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    full_q  <= full_d;
    twice_q <= twice_d;
    alert_q <= alert_d;
    if (out_load) begin
      out_alert_q <= alert_q;
      out_full_q  <= full_q;
      out_twice_q <= twice_q;
      out_count_q <= total_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign alert_o        = out_alert_q;
  assign window_full_o  = out_full_q;
  assign twice_median_o = out_twice_q;
  assign alert_count_o  = out_count_q;

endmodule

`default_nettype wire

FILE: tb/sv/sliding_window_median_alert_tb.sv
`timescale 1ns / 100ps

// Regression bench for the sliding-window median alert block.
//
// Samples go in on a valid/stall channel, and every accepted sample yields
// exactly one result transaction. The bench keeps its own copy of the
// window: a count per bin, a ring of the trailing samples, the fill level
// and the running alert total. It works out the expected result at the
// moment the sample transaction is accepted and queues it. A separate
// process compares every accepted result with the oldest queued one, field
// by field.
//
// The window length register is written over the APB port only while the
// block is idle, which is after reset or once every queued result has come
// back. A write empties the window in the bench's copy just as in the block,
// while the alert total is carried over.
module sliding_window_median_alert_tb;

  localparam int unsigned CYCLE_LIMIT  = 3000000;
  // Idle cycles allowed after the last result before a register write.
  localparam int unsigned CONFIG_SETTLE = 16;
  // Settle time at the end of the run; it covers one full median scan plus update.
  localparam int unsigned END_SETTLE    = 300;

  typedef struct packed {
    logic                           alert;
    logic                           window_full;
    swma_pkg::twice_t               twice_median;
    logic [swma_pkg::TOTAL_W-1:0]   alert_count;
  } median_result_t;

  logic                           clk_i;
  logic                           rst_ni;

  logic                           in_valid_i;
  logic                           in_stall_o;
  swma_pkg::bin_t                 sample_value_i;

  logic                           out_valid_o;
  logic                           out_stall_i;
  logic                           alert_o;
  logic                           window_full_o;
  swma_pkg::twice_t               twice_median_o;
  logic [swma_pkg::TOTAL_W-1:0]   alert_count_o;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [swma_pkg::APB_AW-1:0]    paddr;
  logic [swma_pkg::APB_DW-1:0]    pwdata;
  logic [swma_pkg::APB_DW-1:0]    prdata;
  logic                           pready;

  // The bench's own copy of the window.
  int unsigned                    bin_tally [swma_pkg::NUM_BINS];
  swma_pkg::bin_t                 ring_copy [swma_pkg::WINDOW_MAX];
  int unsigned                    ring_ptr;
  int unsigned                    samples_held;
  logic [swma_pkg::TOTAL_W-1:0]   alerts_so_far;
  swma_pkg::len_t                 length_reg;

  median_result_t                 expected_results [$];

  int unsigned                    error_count;
  int unsigned                    cycle_count;

  // Traffic shaping knobs, in percent of cycles.
  int unsigned                    idle_pct;
  int unsigned                    stall_pct;

  // A long receiver hold-off is requested by bumping the token.
  int unsigned                    hold_token;
  int unsigned                    hold_length;

  sliding_window_median_alert dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .alert_o        (alert_o),
    .window_full_o  (window_full_o),
    .twice_median_o (twice_median_o),
    .alert_count_o  (alert_count_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sliding_window_median_alert regression: fail");
      $finish;
    end
  end

  // Receiver side. Normally it stalls at random by stall_pct. When the test
  // asks for a hold-off, it stalls without a break for the requested number
  // of cycles, which it counts down on its own.
  always @(posedge clk_i) begin : receiver
    int unsigned hold_left;
    int unsigned token_seen;
    if (hold_token != token_seen) begin
      token_seen = hold_token;
      hold_left  = hold_length;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result checker. Every accepted result transaction is held against the
  // oldest expectation still waiting.
  always @(posedge clk_i) begin : result_check
    median_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no sample waiting for it");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (alert_o !== want.alert) begin
          $error("alert mismatch: expected %0d, got %0d", want.alert, alert_o);
          error_count++;
        end
        if (window_full_o !== want.window_full) begin
          $error("window_full mismatch: expected %0d, got %0d",
                 want.window_full, window_full_o);
          error_count++;
        end
        if (twice_median_o !== want.twice_median) begin
          $error("twice_median mismatch: expected %0d, got %0d",
                 want.twice_median, twice_median_o);
          error_count++;
        end
        if (alert_count_o !== want.alert_count) begin
          $error("alert_count mismatch: expected %0d, got %0d",
                 want.alert_count, alert_count_o);
          error_count++;
        end
      end
    end
  end

  // Empties the window copy; the alert total is not touched.
  function automatic void restart_window();
    foreach (bin_tally[b]) bin_tally[b] = 0;
    foreach (ring_copy[i]) ring_copy[i] = '0;
    ring_ptr     = 0;
    samples_held = 0;
  endfunction

  // Smallest bin whose running count reaches the given rank (from 1).
  function automatic int unsigned bin_at_rank(int unsigned rank);
    int unsigned running;
    running = 0;
    for (int b = 0; b < swma_pkg::NUM_BINS; b++) begin
      running += bin_tally[b];
      if (running >= rank) return b;
    end
    return 0;
  endfunction

  // Works out the result for one sample and moves the window copy along.
  function automatic median_result_t predict_median_alert(swma_pkg::bin_t sample);
    median_result_t result;
    int unsigned    span;
    int unsigned    twice;
    int unsigned    oldest;
    result = '0;
    span   = length_reg;
    if (span == 0) span = 1;
    if (span > swma_pkg::WINDOW_MAX) span = swma_pkg::WINDOW_MAX;
    if (samples_held >= span) begin
      // For an odd span both ranks land on the middle sample, so the sum is
      // twice the median; for an even span it is the two middle samples.
      twice = bin_at_rank((span + 1) / 2) + bin_at_rank(span / 2 + 1);
      result.window_full  = 1'b1;
      result.twice_median = swma_pkg::twice_t'(twice);
      if (sample >= twice) begin
        result.alert = 1'b1;
        if (alerts_so_far != '1) alerts_so_far++;
      end
      oldest = ring_copy[ring_ptr];
      if (bin_tally[oldest] != 0) bin_tally[oldest]--;
    end else begin
      samples_held++;
    end
    bin_tally[sample]++;
    ring_copy[ring_ptr] = sample;
    ring_ptr++;
    if (ring_ptr >= span) ring_ptr = 0;
    result.alert_count = alerts_so_far;
    return result;
  endfunction

  // Offers one sample, after a random idle gap, and queues its prediction
  // once the transaction is accepted. Valid is left high on return so that
  // back-to-back samples keep it up without a dip.
  task automatic send_sample(swma_pkg::bin_t value);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.insert(expected_results.size(), predict_median_alert(value));
  endtask

  // Stops offering samples and waits until every result has come back.
  task automatic drain_results(int unsigned settle);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic apb_access(logic write, logic [swma_pkg::APB_DW-1:0] wdata,
                            output logic [swma_pkg::APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {swma_pkg::REG_WINDOW_LENGTH, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_window_length();
    logic [swma_pkg::APB_DW-1:0] readback;
    apb_access(1'b0, '0, readback);
    if (readback !== swma_pkg::APB_DW'(length_reg)) begin
      $error("window_length readback mismatch: expected %0d, got %0d",
             length_reg, readback);
      error_count++;
    end
  endtask

  // Sets a new window length. The block must be idle, so all results are
  // collected first; the write restarts the fill in both block and copy.
  // The bus goes idle for a cycle between the write and the readback.
  task automatic set_window_length(swma_pkg::len_t value);
    logic [swma_pkg::APB_DW-1:0] unused;
    drain_results(CONFIG_SETTLE);
    apb_access(1'b1, swma_pkg::APB_DW'(value), unused);
    length_reg = value;
    restart_window();
    @(posedge clk_i);
    check_window_length();
  endtask

  // Mostly a quiet level with random content, with spikes across the full
  // range and now and then a hard zero or full-scale sample. Spikes well
  // above twice a low median are what raise alerts.
  function automatic swma_pkg::bin_t pick_sample(int unsigned level);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return swma_pkg::bin_t'($urandom_range(level));
    if (roll < 95) return swma_pkg::bin_t'($urandom_range(255));
    return $urandom_range(1) ? '1 : '0;
  endfunction

  // The reset length of five is in force without any write. An all-zero
  // window has a median of zero, so any sample alerts, the equal case
  // included.
  task automatic test_reset_length();
    idle_pct  = 0;
    stall_pct = 0;
    check_window_length();
    repeat (5) send_sample('0);
    send_sample('0);
    send_sample('1);
  endtask

  // Short windows with hand-picked samples: the top bin as the median, an
  // even window where the two middle values differ, a length of zero that
  // acts as one, and samples that land exactly on the threshold.
  task automatic test_window_edges();
    set_window_length(swma_pkg::len_t'(3));
    repeat (3) send_sample(8'd255);
    send_sample(8'd255);
    send_sample(8'd0);

    set_window_length(swma_pkg::len_t'(2));
    send_sample(8'd10);
    send_sample(8'd20);
    send_sample(8'd30);
    send_sample(8'd29);
    send_sample(8'd40);

    set_window_length('0);
    send_sample(8'd7);
    send_sample(8'd14);
    send_sample(8'd13);

    set_window_length(swma_pkg::len_t'(4));
    repeat (3) send_sample(8'd1);
    send_sample(8'd9);
    send_sample(8'd2);
  endtask

  // Random traffic in three blocks, each with its own short window length.
  // The quiet level shifts every so often so the median has to follow it.
  task automatic test_random_traffic(int unsigned idle, int unsigned stall,
                                     int unsigned per_block);
    int unsigned level;
    idle_pct  = idle;
    stall_pct = stall;
    for (int blk = 0; blk < 3; blk++) begin
      if ($urandom_range(9) < 8) begin
        set_window_length(swma_pkg::len_t'($urandom_range(1, 12)));
      end else begin
        set_window_length(swma_pkg::len_t'($urandom_range(13, 40)));
      end
      level = $urandom_range(48);
      for (int i = 0; i < per_block; i++) begin
        if (i % 20 == 19) level = $urandom_range(48);
        send_sample(pick_sample(level));
      end
    end
  endtask

  // The receiver holds off for a long stretch while samples keep coming,
  // so the block backs up and stalls its input. Afterwards the sender waits
  // for each result before it offers the next sample.
  task automatic test_output_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    set_window_length(swma_pkg::len_t'(4));
    hold_length = 2000;
    hold_token++;
    for (int i = 0; i < 30; i++) send_sample(pick_sample(12));
    for (int i = 0; i < 12; i++) begin
      send_sample(pick_sample(12));
      drain_results(0);
    end
  endtask

  // All ones in the register acts as the largest window, so a short run of
  // samples stays within the fill and never forms a median. The largest
  // legal value behaves the same, and the register then goes back to a
  // window of one.
  task automatic test_longest_window();
    idle_pct  = 0;
    stall_pct = 0;
    set_window_length('1);
    for (int i = 0; i < 24; i++) send_sample(pick_sample(20));
    set_window_length(swma_pkg::LEN_MAX);
    for (int i = 0; i < 8; i++) send_sample(pick_sample(20));
    set_window_length(swma_pkg::len_t'(1));
    for (int i = 0; i < 8; i++) send_sample(pick_sample(20));
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    sample_value_i <= '0;
    out_stall_i    <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    error_count    = 0;
    cycle_count    = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_token     = 0;
    hold_length    = 0;
    alerts_so_far  = '0;
    length_reg     = swma_pkg::WL_RESET;
    restart_window();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_length();
    test_window_edges();
    test_random_traffic(0, 0, 45);
    test_random_traffic(51, 0, 45);
    test_random_traffic(0, 51, 45);
    test_random_traffic(30, 30, 45);
    test_output_backpressure();
    test_random_traffic(30, 30, 20);
    test_longest_window();

    drain_results(END_SETTLE);
    if (error_count == 0) begin
      $display("sliding_window_median_alert regression: pass");
    end else begin
      $display("sliding_window_median_alert regression: fail");
    end
    $finish;
  end

endmodule
